// ===== hdl/ljts_pkg.sv =====
package ljts_pkg;

  localparam int unsigned MAX_LEVELS = 16;

  localparam int unsigned DEPTH_W = 5;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ENG_W   = 3;
  localparam int unsigned NODE_W  = 31;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned LEVEL_W = 5;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_START   = 2'd0;
  localparam op_t OP_RELEASE = 2'd1;
  localparam op_t OP_PAIR    = 2'd2;
  localparam op_t OP_CHILD   = 2'd3;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_COUNT    = 3'd0;
  localparam kind_t KIND_BASE     = 3'd1;
  localparam kind_t KIND_READ     = 3'd2;
  localparam kind_t KIND_DISPATCH = 3'd3;
  localparam kind_t KIND_FINISH   = 3'd4;

  typedef struct packed {
    op_t               operation;
    logic [ENG_W-1:0]  released_engine;
    logic [NODE_W-1:0] node_a_in;
    logic [NODE_W-1:0] node_b_in;
    logic [CNT_W-1:0]  child_pairs;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [CNT_W-1:0]  pair_count;
    logic [ADDR_W-1:0] cache_addr;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [ENG_W-1:0]  join_engine;
    logic              last;
  } result_t;

endpackage

// ===== hdl/ljts_if.sv =====
interface ljts_in_if;
  logic                        valid;
  logic                        ready;
  ljts_pkg::op_t               operation;
  logic [ljts_pkg::ENG_W-1:0]  released_engine;
  logic [ljts_pkg::NODE_W-1:0] node_a_in;
  logic [ljts_pkg::NODE_W-1:0] node_b_in;
  logic [ljts_pkg::CNT_W-1:0]  child_pairs;

  modport source (
    output valid, operation, released_engine, node_a_in, node_b_in, child_pairs,
    input  ready
  );
  modport sink (
    input  valid, operation, released_engine, node_a_in, node_b_in, child_pairs,
    output ready
  );
endinterface

interface ljts_out_if;
  logic                        valid;
  logic                        ready;
  ljts_pkg::kind_t             kind;
  logic [ljts_pkg::CNT_W-1:0]  pair_count;
  logic [ljts_pkg::ADDR_W-1:0] cache_addr;
  logic [ljts_pkg::NODE_W-1:0] node_a;
  logic [ljts_pkg::NODE_W-1:0] node_b;
  logic [ljts_pkg::ENG_W-1:0]  join_engine;
  logic                        last;

  modport source (
    output valid, kind, pair_count, cache_addr, node_a, node_b, join_engine, last,
    input  ready
  );
  modport sink (
    input  valid, kind, pair_count, cache_addr, node_a, node_b, join_engine, last,
    output ready
  );
endinterface

// ===== hdl/level_join_task_scheduler.sv =====
// An accepted input beat passes the input register, the quotient register and the child-count
// reduction by the cache depth; the decision stage then writes its results into the result register.
// Throughput: one input beat per cycle while the result port keeps up; an item with k results
// holds the single result port for k beats (k is 0 to 3), so the result port sets the sustained rate.
// Reset (rst_ni low, asynchronous): phase idle, all engines idle, depths 0, pipeline empty.
module level_join_task_scheduler #(
  parameter int unsigned NUM_ENGINES = 8,
  parameter int unsigned CACHE_DEPTH = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [ljts_pkg::DEPTH_W-1:0]   cfg_data_i,
  ljts_in_if.sink                        req_i,
  ljts_out_if.source                     rsp_o
);

  localparam int unsigned AW  = $clog2(CACHE_DEPTH);
  localparam int unsigned EW  = (NUM_ENGINES > 1) ? $clog2(NUM_ENGINES) : 1;
  localparam int unsigned SW  = ((AW > 16) ? AW : 16) + 1;
  localparam bit          RED = CACHE_DEPTH < 65536;
  localparam int unsigned RSH = 16 + AW;
  localparam longint unsigned RMUL = RED ?
      (((64'd1 << RSH) + 64'(CACHE_DEPTH) - 64'd1) / 64'(CACHE_DEPTH)) : 64'd1;
  localparam logic [17:0] RMUL18 = 18'(RMUL);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PAIR,
    PH_ENGINE,
    PH_CHILD
  } phase_e;

  typedef struct packed {
    ljts_pkg::item_t  item;
    logic [15:0]      quot;
  } stg2_t;

  typedef struct packed {
    ljts_pkg::item_t  item;
    logic [15:0]      pmod;
  } stg3_t;

  function automatic logic [15:0] addr16(input logic [AW-1:0] a);
    logic [AW+15:0] w;
    w = {16'b0, a};
    return w[15:0];
  endfunction

  function automatic logic [2:0] eng3(input logic [EW-1:0] e);
    logic [EW+2:0] w;
    w = {3'b0, e};
    return w[2:0];
  endfunction

  function automatic ljts_pkg::result_t mk_res(
    input ljts_pkg::kind_t              kind,
    input logic [15:0]                  count,
    input logic [15:0]                  addr,
    input logic [ljts_pkg::NODE_W-1:0]  na,
    input logic [ljts_pkg::NODE_W-1:0]  nb,
    input logic [2:0]                   eng
  );
    ljts_pkg::result_t r;
    r.kind        = kind;
    r.pair_count  = count;
    r.cache_addr  = addr;
    r.node_a      = na;
    r.node_b      = nb;
    r.join_engine = eng;
    r.last        = 1'b0;
    return r;
  endfunction

  // Input pipeline: raw beat, quotient, reduced child count
  logic            s1_v_q, s2_v_q, s3_v_q;
  ljts_pkg::item_t s1_q;
  stg2_t           s2_q;
  stg3_t           s3_q;
  logic            s1_ld, s2_ld, s3_ld, fire;
  logic [33:0]     q_prod;
  logic [31:0]     qd_prod;
  logic [31:0]     rem;
  logic [15:0]     pmod;

  assign s3_ld = s2_v_q && (!s3_v_q || fire);
  assign s2_ld = s1_v_q && (!s2_v_q || s3_ld);
  assign s1_ld = req_i.valid && req_i.ready;
  assign req_i.ready = !s1_v_q || s2_ld;

  assign q_prod = 34'(s1_q.child_pairs) * 34'(RMUL18);

  always_comb begin
    qd_prod = 32'(s2_q.quot) * 32'(CACHE_DEPTH);
    rem     = 32'(s2_q.item.child_pairs) - qd_prod;
    if (rem >= 32'(CACHE_DEPTH)) begin
      rem = rem - 32'(CACHE_DEPTH);
    end
    pmod = RED ? rem[15:0] : s2_q.item.child_pairs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_v_q <= 1'b1;
      end else if (s2_ld) begin
        s1_v_q <= 1'b0;
      end
      if (s2_ld) begin
        s2_v_q <= 1'b1;
      end else if (s3_ld) begin
        s2_v_q <= 1'b0;
      end
      if (s3_ld) begin
        s3_v_q <= 1'b1;
      end else if (fire) begin
        s3_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ld) begin
      s1_q.operation       <= req_i.operation;
      s1_q.released_engine <= req_i.released_engine;
      s1_q.node_a_in       <= req_i.node_a_in;
      s1_q.node_b_in       <= req_i.node_b_in;
      s1_q.child_pairs     <= req_i.child_pairs;
    end
    if (s2_ld) begin
      s2_q.item <= s1_q;
      s2_q.quot <= 16'(q_prod >> RSH);
    end
    if (s3_ld) begin
      s3_q.item <= s2_q.item;
      s3_q.pmod <= pmod;
    end
  end

  // Scheduler state
  phase_e                          phase_q, phase_d;
  logic [ljts_pkg::LEVEL_W-1:0]    level_q, level_d;
  logic [15:0]                     join_idx_q, join_idx_d;
  logic [15:0]                     pairs_q, pairs_d;
  logic [AW-1:0]                   cur_base_q, cur_base_d;
  logic [AW-1:0]                   rd_ptr_q, rd_ptr_d;
  logic [NUM_ENGINES-1:0]          busy_q, busy_d;
  logic [ljts_pkg::NODE_W-1:0]     held_a_q, held_a_d, held_b_q, held_b_d;
  logic [ljts_pkg::DEPTH_W-1:0]    depth_a_q, depth_b_q;

  // Result bundle, drained one beat per cycle while the sink is ready
  ljts_pkg::result_t               bnd_q [3];
  logic [1:0]                      bnd_left_q, bnd_pos_q;
  logic                            pop, bnd_free;

  ljts_pkg::result_t               res_d [3];
  logic [1:0]                      res_cnt;
  logic [ljts_pkg::DEPTH_W-1:0]    depth_max;
  logic [6:0]                      lvl_total;
  logic [SW-1:0]                   base_sum;
  logic [AW-1:0]                   cur_wrap;
  logic [AW-1:0]                   rd_next;
  logic                            rel_ok;
  logic [NUM_ENGINES-1:0]          rel_mask, bv, sel_oh;
  logic [EW-1:0]                   free_idx;
  logic                            do_disp;
  logic [ljts_pkg::NODE_W-1:0]     disp_a, disp_b;
  ljts_pkg::item_t                 it;

  assign it = s3_q.item;

  always_comb begin
    depth_max = (depth_a_q > depth_b_q) ? depth_a_q : depth_b_q;
    lvl_total = (7'(depth_max) > 7'(ljts_pkg::MAX_LEVELS)) ?
                7'(ljts_pkg::MAX_LEVELS) : 7'(depth_max);
    base_sum  = SW'(cur_base_q) + SW'(s3_q.pmod);
    cur_wrap  = (base_sum >= SW'(CACHE_DEPTH)) ?
                AW'(base_sum - SW'(CACHE_DEPTH)) : AW'(base_sum);
    rd_next   = (rd_ptr_q == AW'(CACHE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    rel_ok    = 32'(it.released_engine) < NUM_ENGINES;
    for (int i = 0; i < NUM_ENGINES; i++) begin
      rel_mask[i] = rel_ok && (32'(it.released_engine) == i);
    end
  end

  always_comb begin
    phase_d    = phase_q;
    level_d    = level_q;
    join_idx_d = join_idx_q;
    pairs_d    = pairs_q;
    cur_base_d = cur_base_q;
    rd_ptr_d   = rd_ptr_q;
    busy_d     = busy_q;
    held_a_d   = held_a_q;
    held_b_d   = held_b_q;
    res_cnt    = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res_d[k] = '0;
    end
    bv      = busy_q;
    do_disp = 1'b0;
    disp_a  = held_a_q;
    disp_b  = held_b_q;

    unique case (it.operation)
      ljts_pkg::OP_START: begin
        if (phase_q == PH_IDLE) begin
          busy_d     = '0;
          join_idx_d = '0;
          if (lvl_total == 7'd0) begin
            level_d  = '0;
            res_d[0] = mk_res(ljts_pkg::KIND_FINISH, '0, '0, '0, '0, '0);
            res_cnt  = 2'd1;
          end else begin
            // Level one joins the root pair; the cache starts at address zero.
            level_d    = 5'd1;
            pairs_d    = 16'd1;
            cur_base_d = AW'(1);
            rd_ptr_d   = '0;
            res_d[0]   = mk_res(ljts_pkg::KIND_COUNT, 16'd1, '0, '0, '0, '0);
            res_d[1]   = mk_res(ljts_pkg::KIND_BASE, '0, addr16(AW'(1)), '0, '0, '0);
            res_d[2]   = mk_res(ljts_pkg::KIND_READ, '0, '0, '0, '0, '0);
            res_cnt    = 2'd3;
            phase_d    = PH_PAIR;
          end
        end
      end
      ljts_pkg::OP_RELEASE: begin
        if (phase_q != PH_IDLE && rel_ok) begin
          bv      = busy_q & ~rel_mask;
          busy_d  = bv;
          do_disp = (phase_q == PH_ENGINE);
        end
      end
      ljts_pkg::OP_PAIR: begin
        if (phase_q == PH_PAIR) begin
          held_a_d = it.node_a_in;
          held_b_d = it.node_b_in;
          disp_a   = it.node_a_in;
          disp_b   = it.node_b_in;
          do_disp  = 1'b1;
        end
      end
      ljts_pkg::OP_CHILD: begin
        if (phase_q == PH_CHILD) begin
          level_d    = level_q + 1'b1;
          pairs_d    = it.child_pairs;
          cur_base_d = cur_wrap;
          join_idx_d = '0;
          rd_ptr_d   = cur_base_q;
          res_d[0]   = mk_res(ljts_pkg::KIND_COUNT, it.child_pairs, '0, '0, '0, '0);
          res_d[1]   = mk_res(ljts_pkg::KIND_BASE, '0, addr16(cur_wrap), '0, '0, '0);
          if (it.child_pairs != '0) begin
            res_d[2] = mk_res(ljts_pkg::KIND_READ, '0, addr16(cur_base_q), '0, '0, '0);
            res_cnt  = 2'd3;
            phase_d  = PH_PAIR;
          end else if (7'(level_d) < lvl_total) begin
            res_cnt = 2'd2;
            phase_d = PH_CHILD;
          end else begin
            res_d[2] = mk_res(ljts_pkg::KIND_FINISH, '0, '0, '0, '0, '0);
            res_cnt  = 2'd3;
            phase_d  = PH_IDLE;
          end
        end
      end
      default: ;
    endcase

    // Lowest idle engine
    sel_oh   = ~bv & (bv + 1'b1);
    free_idx = '0;
    for (int i = 0; i < NUM_ENGINES; i++) begin
      if (sel_oh[i]) begin
        free_idx = free_idx | EW'(i);
      end
    end

    if (do_disp) begin
      if (sel_oh != '0) begin
        busy_d     = bv | sel_oh;
        res_d[0]   = mk_res(ljts_pkg::KIND_DISPATCH, '0, '0, disp_a, disp_b,
                            eng3(free_idx));
        join_idx_d = join_idx_q + 1'b1;
        if (join_idx_d < pairs_q) begin
          rd_ptr_d = rd_next;
          res_d[1] = mk_res(ljts_pkg::KIND_READ, '0, addr16(rd_next), '0, '0, '0);
          res_cnt  = 2'd2;
          phase_d  = PH_PAIR;
        end else if (7'(level_q) < lvl_total) begin
          res_cnt = 2'd1;
          phase_d = PH_CHILD;
        end else begin
          res_d[1] = mk_res(ljts_pkg::KIND_FINISH, '0, '0, '0, '0, '0);
          res_cnt  = 2'd2;
          phase_d  = PH_IDLE;
        end
      end else begin
        phase_d = PH_ENGINE;
      end
    end

    if (res_cnt != 2'd0) begin
      res_d[res_cnt - 2'd1].last = 1'b1;
    end
  end

  assign pop      = rsp_o.valid && rsp_o.ready;
  assign bnd_free = (bnd_left_q == 2'd0) || (bnd_left_q == 2'd1 && pop);
  assign fire     = s3_v_q && ((res_cnt == 2'd0) || bnd_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      level_q    <= '0;
      join_idx_q <= '0;
      pairs_q    <= '0;
      cur_base_q <= '0;
      rd_ptr_q   <= '0;
      busy_q     <= '0;
      held_a_q   <= '0;
      held_b_q   <= '0;
      depth_a_q  <= '0;
      depth_b_q  <= '0;
      bnd_left_q <= '0;
      bnd_pos_q  <= '0;
      for (int k = 0; k < 3; k++) begin
        bnd_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i) begin
          depth_b_q <= cfg_data_i;
        end else begin
          depth_a_q <= cfg_data_i;
        end
      end
      if (fire) begin
        phase_q    <= phase_d;
        level_q    <= level_d;
        join_idx_q <= join_idx_d;
        pairs_q    <= pairs_d;
        cur_base_q <= cur_base_d;
        rd_ptr_q   <= rd_ptr_d;
        busy_q     <= busy_d;
        held_a_q   <= held_a_d;
        held_b_q   <= held_b_d;
      end
      if (fire && res_cnt != 2'd0) begin
        for (int k = 0; k < 3; k++) begin
          bnd_q[k] <= res_d[k];
        end
        bnd_left_q <= res_cnt;
        bnd_pos_q  <= 2'd0;
      end else if (pop) begin
        bnd_left_q <= bnd_left_q - 1'b1;
        bnd_pos_q  <= bnd_pos_q + 1'b1;
      end
    end
  end

  assign rsp_o.valid       = bnd_left_q != 2'd0;
  assign rsp_o.kind        = bnd_q[bnd_pos_q].kind;
  assign rsp_o.pair_count  = bnd_q[bnd_pos_q].pair_count;
  assign rsp_o.cache_addr  = bnd_q[bnd_pos_q].cache_addr;
  assign rsp_o.node_a      = bnd_q[bnd_pos_q].node_a;
  assign rsp_o.node_b      = bnd_q[bnd_pos_q].node_b;
  assign rsp_o.join_engine = bnd_q[bnd_pos_q].join_engine;
  assign rsp_o.last        = bnd_q[bnd_pos_q].last;

endmodule

// ===== verif/tb_level_join_task_scheduler.sv =====
`timescale 1ns / 100ps

module tb_level_join_task_scheduler;

  localparam int unsigned NUM_ENG       = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS  = 96;
  localparam int unsigned CALM_FROM     = 76;

  localparam int unsigned DEPTH_W = ljts_pkg::DEPTH_W;
  localparam int unsigned ENG_W   = ljts_pkg::ENG_W;
  localparam int unsigned NODE_W  = ljts_pkg::NODE_W;
  localparam int unsigned CNT_W   = ljts_pkg::CNT_W;
  localparam int unsigned ADDR_W  = ljts_pkg::ADDR_W;
  localparam int unsigned LEVEL_W = ljts_pkg::LEVEL_W;

  localparam logic REG_DEPTH_A = 1'b0;
  localparam logic REG_DEPTH_B = 1'b1;

  localparam logic [NODE_W-1:0] NODE_MAX = '1;

  typedef enum logic [1:0] {PH_IDLE, PH_PAIR, PH_ENGINE, PH_CHILD} sched_phase_e;

  typedef struct packed {
    sched_phase_e       phase;
    logic [LEVEL_W-1:0] level;
    logic [CNT_W-1:0]   join_index;
    logic [CNT_W-1:0]   level_pairs;
    logic [ADDR_W-1:0]  prev_base;
    logic [ADDR_W-1:0]  cur_base;
    logic [NUM_ENG-1:0] busy;
    logic [NODE_W-1:0]  held_a;
    logic [NODE_W-1:0]  held_b;
    logic [DEPTH_W-1:0] depth_a;
    logic [DEPTH_W-1:0] depth_b;
  } sched_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic                cfg_idx;
  logic [DEPTH_W-1:0]  cfg_data;

  ljts_in_if  req_if ();
  ljts_out_if rsp_if ();

  level_join_task_scheduler i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  ljts_pkg::item_t   backlog[$];
  ljts_pkg::result_t due_results[$];
  sched_t            sched_model;
  sched_t            sched_plan;

  bit beat_taken;
  bit calm;
  int send_gap;
  int stall_left;
  int errors;
  int beats_in;
  int beats_out;
  int cfg_writes;
  int runs_done;
  int cycles;

  // ---------------------------------------------------------------------------
  // Scheduler prediction
  // ---------------------------------------------------------------------------

  function automatic void emit(inout ljts_pkg::result_t [2:0] r, inout int n,
                               input ljts_pkg::kind_t k,
                               input logic [CNT_W-1:0] cnt, input logic [ADDR_W-1:0] addr,
                               input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                               input logic [ENG_W-1:0] e);
    r[n] = '{kind: k, pair_count: cnt, cache_addr: addr, node_a: a, node_b: b,
             join_engine: e, last: 1'b0};
    n++;
  endfunction

  function automatic int unsigned level_count(input sched_t s);
    int unsigned m;
    m = (s.depth_a > s.depth_b) ? 32'(s.depth_a) : 32'(s.depth_b);
    return (m > ljts_pkg::MAX_LEVELS) ? ljts_pkg::MAX_LEVELS : m;
  endfunction

  function automatic void pair_or_end(inout sched_t s, inout ljts_pkg::result_t [2:0] r,
                                      inout int n);
    if (s.join_index < s.level_pairs) begin
      emit(r, n, ljts_pkg::KIND_READ, '0, s.prev_base + s.join_index, '0, '0, '0);
      s.phase = PH_PAIR;
    end else if (32'(s.level) < level_count(s)) begin
      s.phase = PH_CHILD;
    end else begin
      emit(r, n, ljts_pkg::KIND_FINISH, '0, '0, '0, '0, '0);
      s.phase = PH_IDLE;
    end
  endfunction

  function automatic void open_level(inout sched_t s, inout ljts_pkg::result_t [2:0] r,
                                     inout int n);
    // 16-bit sum wraps at the cache depth
    s.cur_base   = s.prev_base + s.level_pairs;
    s.join_index = '0;
    emit(r, n, ljts_pkg::KIND_COUNT, s.level_pairs, '0, '0, '0, '0);
    emit(r, n, ljts_pkg::KIND_BASE, '0, s.cur_base, '0, '0, '0);
    pair_or_end(s, r, n);
  endfunction

  function automatic void dispatch(inout sched_t s, inout ljts_pkg::result_t [2:0] r,
                                   inout int n);
    bit found;
    int e;
    found = 1'b0;
    for (e = 0; e < NUM_ENG; e++) begin
      if (!found && !s.busy[e]) begin
        found     = 1'b1;
        s.busy[e] = 1'b1;
        emit(r, n, ljts_pkg::KIND_DISPATCH, '0, '0, s.held_a, s.held_b, ENG_W'(e));
        s.join_index = s.join_index + 1'b1;
        pair_or_end(s, r, n);
      end
    end
    if (!found) s.phase = PH_ENGINE;
  endfunction

  function automatic void schedule_step(inout sched_t s, input ljts_pkg::item_t it,
                                        output ljts_pkg::result_t [2:0] r, output int n);
    n = 0;
    r = '0;
    case (it.operation)
      ljts_pkg::OP_START: begin
        if (s.phase == PH_IDLE) begin
          s.busy       = '0;
          s.prev_base  = '0;
          s.join_index = '0;
          if (level_count(s) == 0) begin
            s.level = '0;
            emit(r, n, ljts_pkg::KIND_FINISH, '0, '0, '0, '0, '0);
          end else begin
            s.level       = LEVEL_W'(1);
            s.level_pairs = CNT_W'(1);
            open_level(s, r, n);
          end
        end
      end
      ljts_pkg::OP_RELEASE: begin
        if (s.phase != PH_IDLE) begin
          s.busy[it.released_engine] = 1'b0;
          if (s.phase == PH_ENGINE) dispatch(s, r, n);
        end
      end
      ljts_pkg::OP_PAIR: begin
        if (s.phase == PH_PAIR) begin
          s.held_a = it.node_a_in;
          s.held_b = it.node_b_in;
          dispatch(s, r, n);
        end
      end
      default: begin
        if (s.phase == PH_CHILD) begin
          s.prev_base   = s.cur_base;
          s.level       = s.level + 1'b1;
          s.level_pairs = it.child_pairs;
          open_level(s, r, n);
        end
      end
    endcase
    if (n > 0) r[n-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("level_join_task_scheduler verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and result sink, both change at the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin : drive
    logic rdy;
    if (rst_ni) begin
      if (!req_if.valid || beat_taken) begin
        beat_taken = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (backlog.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 3);
            req_if.valid <= 1'b0;
          end else begin
            req_if.valid           <= 1'b1;
            req_if.operation       <= backlog[0].operation;
            req_if.released_engine <= backlog[0].released_engine;
            req_if.node_a_in       <= backlog[0].node_a_in;
            req_if.node_b_in       <= backlog[0].node_b_in;
            req_if.child_pairs     <= backlog[0].child_pairs;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      rsp_if.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted input beats, check result beats
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : monitor
    ljts_pkg::item_t          got_in;
    ljts_pkg::result_t        got;
    ljts_pkg::result_t        want;
    ljts_pkg::result_t [2:0]  res;
    int                       n;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        got_in = '{operation: req_if.operation, released_engine: req_if.released_engine,
                   node_a_in: req_if.node_a_in, node_b_in: req_if.node_b_in,
                   child_pairs: req_if.child_pairs};
        schedule_step(sched_model, got_in, res, n);
        for (int i = 0; i < n; i++) due_results.push_back(res[i]);
        void'(backlog.pop_front());
        beat_taken = 1'b1;
        beats_in++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{kind: rsp_if.kind, pair_count: rsp_if.pair_count,
                cache_addr: rsp_if.cache_addr, node_a: rsp_if.node_a,
                node_b: rsp_if.node_b, join_engine: rsp_if.join_engine,
                last: rsp_if.last};
        beats_out++;
        if (got.kind == ljts_pkg::KIND_FINISH) runs_done++;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result beat kind %0d addr %0d", $realtime,
                     got.kind, got.cache_addr);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch (want/got) kind %0d/%0d count %0d/%0d addr %0d/%0d",
                       $realtime, want.kind, got.kind, want.pair_count, got.pair_count,
                       want.cache_addr, got.cache_addr);
              $display("  a %h/%h b %h/%h eng %0d/%0d last %0d/%0d",
                       want.node_a, got.node_a, want.node_b, got.node_b,
                       want.join_engine, got.join_engine, want.last, got.last);
            end
          end
        end
      end
      if (cfg_we) begin
        if (cfg_idx == REG_DEPTH_A) sched_model.depth_a = cfg_data;
        else sched_model.depth_b = cfg_data;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic ljts_pkg::item_t mk(input ljts_pkg::op_t op, input logic [ENG_W-1:0] eng,
                                         input logic [NODE_W-1:0] a,
                                         input logic [NODE_W-1:0] b,
                                         input logic [CNT_W-1:0] cp);
    return '{operation: op, released_engine: eng, node_a_in: a, node_b_in: b,
             child_pairs: cp};
  endfunction

  // queue a beat and keep the planning copy in step with it
  task automatic send(input ljts_pkg::item_t it);
    ljts_pkg::result_t [2:0] res;
    int                      n;
    backlog.push_back(it);
    schedule_step(sched_plan, it, res, n);
  endtask

  // hold the sender until every expected result is back and the pipeline is empty
  task automatic settle();
    do @(posedge clk_i); while (backlog.size() != 0 || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_depth(input logic idx, input logic [DEPTH_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_DEPTH_A) sched_plan.depth_a = val;
    else sched_plan.depth_b = val;
    cfg_writes++;
  endtask

  function automatic logic [DEPTH_W-1:0] pick_depth();
    case ($urandom_range(0, 9))
      0: return DEPTH_W'(0);
      1: return DEPTH_W'(16);
      2: return DEPTH_W'(8);
      default: return DEPTH_W'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin : stim
    ljts_pkg::item_t it;
    int              sent;
    int              k;

    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = REG_DEPTH_A;
    cfg_data               = '0;
    req_if.valid           = 1'b0;
    req_if.operation       = ljts_pkg::OP_START;
    req_if.released_engine = '0;
    req_if.node_a_in       = '0;
    req_if.node_b_in       = '0;
    req_if.child_pairs     = '0;
    rsp_if.ready           = 1'b0;
    sched_model            = '0;
    sched_plan             = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero depth, and beats that arrive in the wrong phase while idle
    write_depth(REG_DEPTH_A, DEPTH_W'(0));
    write_depth(REG_DEPTH_B, DEPTH_W'(0));
    send(mk(ljts_pkg::OP_RELEASE, ENG_W'(5), '0, '0, '0));
    send(mk(ljts_pkg::OP_PAIR, ENG_W'(0), NODE_MAX, NODE_MAX, '0));
    send(mk(ljts_pkg::OP_CHILD, ENG_W'(7), '0, '0, '1));
    send(mk(ljts_pkg::OP_START, ENG_W'(0), '0, '0, '0));
    settle();

    // two levels, the second one empty; stray pair and start mid-run
    write_depth(REG_DEPTH_A, DEPTH_W'(2));
    write_depth(REG_DEPTH_B, DEPTH_W'(1));
    send(mk(ljts_pkg::OP_START, ENG_W'(0), '0, '0, '0));
    send(mk(ljts_pkg::OP_PAIR, ENG_W'(0), NODE_MAX, '0, '0));
    send(mk(ljts_pkg::OP_PAIR, ENG_W'(0), '0, '0, '0));
    send(mk(ljts_pkg::OP_START, ENG_W'(0), '0, '0, '0));
    send(mk(ljts_pkg::OP_CHILD, ENG_W'(0), '0, '0, '0));
    settle();

    // three levels: fill every engine, wait for a release, release an idle engine
    write_depth(REG_DEPTH_A, DEPTH_W'(1));
    write_depth(REG_DEPTH_B, DEPTH_W'(3));
    send(mk(ljts_pkg::OP_START, ENG_W'(0), '0, '0, '0));
    send(mk(ljts_pkg::OP_PAIR, ENG_W'(0), '0, NODE_MAX, '0));
    send(mk(ljts_pkg::OP_CHILD, ENG_W'(0), '0, '0, CNT_W'(8)));
    for (k = 0; k < 8; k++)
      send(mk(ljts_pkg::OP_PAIR, ENG_W'(0), NODE_W'($urandom()), NODE_W'($urandom()), '0));
    send(mk(ljts_pkg::OP_RELEASE, ENG_W'(0), '0, '0, '0));
    send(mk(ljts_pkg::OP_RELEASE, ENG_W'(4), '0, '0, '0));
    send(mk(ljts_pkg::OP_RELEASE, ENG_W'(4), '0, '0, '0));
    send(mk(ljts_pkg::OP_CHILD, ENG_W'(0), '0, '0, CNT_W'(1)));
    send(mk(ljts_pkg::OP_PAIR, ENG_W'(0), NODE_W'($urandom()), NODE_W'($urandom()), '0));

    for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
      if (sent == CALM_FROM) calm = 1'b1;
      it = mk(ljts_pkg::OP_START, ENG_W'($urandom()), NODE_W'($urandom()),
              NODE_W'($urandom()), CNT_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 9) == 0) begin
        it.operation = ljts_pkg::op_t'($urandom_range(0, 3));
        // keep huge child counts to beats the block ignores
        if (!(it.operation == ljts_pkg::OP_CHILD && sched_plan.phase == PH_CHILD))
          it.child_pairs = CNT_W'($urandom());
      end else begin
        case (sched_plan.phase)
          PH_IDLE: begin
            if ($urandom_range(0, 1) == 0) begin
              settle();
              if ($urandom_range(0, 2) != 0) write_depth(REG_DEPTH_A, pick_depth());
              if ($urandom_range(0, 2) != 0) write_depth(REG_DEPTH_B, pick_depth());
            end
            it.operation = ljts_pkg::OP_START;
          end
          PH_PAIR: begin
            it.operation = ($urandom_range(0, 4) == 0) ? ljts_pkg::OP_RELEASE :
                                                         ljts_pkg::OP_PAIR;
            case ($urandom_range(0, 7))
              0: it.node_a_in = NODE_MAX;
              1: it.node_b_in = '0;
              default: ;
            endcase
          end
          PH_ENGINE: it.operation = ljts_pkg::OP_RELEASE;
          default: begin
            // depth is read live: change it between levels now and then
            if ($urandom_range(0, 7) == 0) begin
              settle();
              write_depth(logic'($urandom_range(0, 1)), DEPTH_W'($urandom_range(0, 12)));
            end
            it.operation = ($urandom_range(0, 9) == 0) ? ljts_pkg::OP_RELEASE :
                                                         ljts_pkg::OP_CHILD;
            if ($urandom_range(0, 19) >= 14) it.child_pairs = CNT_W'($urandom_range(4, 12));
          end
        endcase
      end
      send(it);
    end

    settle();
    $display("run covered %0d input beats, %0d result beats, %0d register writes",
             beats_in, beats_out, cfg_writes);
    $display("%0d runs reached their finish; %0d mismatches", runs_done, errors);
    if (errors == 0 && due_results.size() == 0) begin
      $display("level_join_task_scheduler verification clean");
    end else begin
      $display("level_join_task_scheduler verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ljts_pkg.sv
hdl/ljts_if.sv
hdl/level_join_task_scheduler.sv
verif/tb_level_join_task_scheduler.sv
